>>> rtl/rht_pkg.sv
// ----------------------------------------------------------------------------
// rht_pkg
// Shared types, codes and helpers for the refcounted handle table.
// ----------------------------------------------------------------------------
`default_nettype none

package rht_pkg;

  // Fixed field widths
  localparam int MODE_W     = 3;
  localparam int DESC_W     = 8;
  localparam int STAT_W     = 2;
  localparam int FID_PORT_W = 32;
  localparam int REF_W      = 7;

  // Defaults for the top-level parameters
  localparam int DEF_TABLE_SIZE   = 64;
  localparam int DEF_FILE_ID_BITS = 32;

  localparam logic [DESC_W-1:0] BASE_RESET = 8'd64;

  localparam logic [REF_W-1:0] REF_MAX = 7'd127;
  localparam logic [REF_W-1:0] REF_ONE = 7'd1;
  localparam logic [REF_W-1:0] REF_ZERO = 7'd0;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_OPEN   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CLOSE  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DUP    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DUP2   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] STS_OK          = 2'd0;
  localparam logic [STAT_W-1:0] STS_INVALID     = 2'd1;
  localparam logic [STAT_W-1:0] STS_FULL        = 2'd2;
  localparam logic [STAT_W-1:0] STS_UNSUPPORTED = 2'd3;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  // Table write strobes from the sequencer
  typedef struct packed {
    logic slot_set;
    logic slot_clr;
    logic obj_set;
    logic obj_clr;
    logic map_we;
    logic file_we;
    logic refs_we;
  } store_cmd_t;

  function automatic logic [REF_W-1:0] ref_dec(input logic [REF_W-1:0] r);
    return (r != REF_ZERO) ? r - REF_ONE : REF_ZERO;
  endfunction

  function automatic logic [REF_W-1:0] ref_inc(input logic [REF_W-1:0] r);
    return (r != REF_MAX) ? r + REF_ONE : r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/rht_if.sv
// ----------------------------------------------------------------------------
// rht_if
// Valid/ready channels for request and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface rht_in_if;
  import rht_pkg::*;

  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [DESC_W-1:0]   descriptor;
  logic [DESC_W-1:0]   target_descriptor;
  logic [FID_PORT_W-1:0] new_file_id;

  modport source (output valid, mode, descriptor, target_descriptor, new_file_id,
                  input ready);
  modport sink (input valid, mode, descriptor, target_descriptor, new_file_id,
                output ready);
endinterface

interface rht_out_if;
  import rht_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [STAT_W-1:0]     status;
  logic [DESC_W-1:0]     result_descriptor;
  logic [FID_PORT_W-1:0] file_id_out;
  logic                  release_file;

  modport source (output valid, status, result_descriptor, file_id_out, release_file,
                  input ready);
  modport sink (input valid, status, result_descriptor, file_id_out, release_file,
                output ready);
endinterface

`default_nettype wire

>>> rtl/refcounted_handle_table_top.sv
// ----------------------------------------------------------------------------
// refcounted_handle_table_top
// Descriptor table engine: slots point to shared, reference-counted objects
// that hold server file ids. Supports open, close, dup, dup2 and lookup.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake        | beat contents
//  ---------+-----+------------------+---------------------------------------
//  in_bus   | in  | valid/ready      | mode, descriptor, target_descriptor,
//           |     |                  | new_file_id
//  out_bus  | out | valid/ready      | status, result_descriptor,
//           |     |                  | file_id_out, release_file
//  cfg      | in  | cfg_we, no ready | cfg_data -> descriptor_base
//
//  States, accept to result valid, one request at a time: an unknown mode
//  goes decode, done; a dead descriptor decode, target decode, slot read,
//  done; close, lookup and dup2 onto itself or off the table add the object
//  read; dup2 then links (closing an open target first). Open and dup scan one
//  entry per cycle up to the first free entries or the last, then allocate.
//  Reset: synchronous, active low; valid maps clear, descriptor_base is 64.
//  Stalls: a full output register holds the next op in its done state.
//
`default_nettype none

module refcounted_handle_table_top #(
  parameter int TABLE_SIZE   = rht_pkg::DEF_TABLE_SIZE,
  parameter int FILE_ID_BITS = rht_pkg::DEF_FILE_ID_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [rht_pkg::DESC_W-1:0] cfg_data,
  rht_in_if.sink                     in_bus,
  rht_out_if.source                  out_bus
);
  import rht_pkg::*;

  localparam int IW = $clog2(TABLE_SIZE);

  logic [FILE_ID_BITS-1:0] in_fid;
  logic [FILE_ID_BITS-1:0] out_fid;

  alu_op_t           alu_op;
  logic [DESC_W-1:0] alu_a;
  logic [DESC_W-1:0] alu_b;
  logic [DESC_W:0]   alu_res;

  store_cmd_t              st_cmd;
  logic [IW-1:0]           slot_addr;
  logic [IW-1:0]           obj_addr;
  logic [IW-1:0]           map_wdata;
  logic [FILE_ID_BITS-1:0] file_wdata;
  logic [REF_W-1:0]        refs_wdata;
  logic [TABLE_SIZE-1:0]   slot_valid;
  logic [TABLE_SIZE-1:0]   obj_valid;
  logic [IW-1:0]           map_rdata;
  logic [FILE_ID_BITS-1:0] file_rdata;
  logic [REF_W-1:0]        refs_rdata;

  // File ids are kept at FILE_ID_BITS; the port is fixed width.
  // Narrow ids drop upper input bits and zero-fill out; wide ids the reverse.
  if (FILE_ID_BITS >= FID_PORT_W) begin : g_fid_wide
    assign in_fid              = FILE_ID_BITS'(in_bus.new_file_id);
    assign out_bus.file_id_out = out_fid[FID_PORT_W-1:0];
  end else begin : g_fid_narrow
    assign in_fid              = in_bus.new_file_id[FILE_ID_BITS-1:0];
    assign out_bus.file_id_out = FID_PORT_W'(out_fid);
  end

  rht_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  rht_store #(
    .TABLE_SIZE   (TABLE_SIZE),
    .FILE_ID_BITS (FILE_ID_BITS)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (st_cmd),
    .slot_addr  (slot_addr),
    .obj_addr   (obj_addr),
    .map_wdata  (map_wdata),
    .file_wdata (file_wdata),
    .refs_wdata (refs_wdata),
    .slot_valid (slot_valid),
    .obj_valid  (obj_valid),
    .map_rdata  (map_rdata),
    .file_rdata (file_rdata),
    .refs_rdata (refs_rdata)
  );

  rht_ctrl #(
    .TABLE_SIZE   (TABLE_SIZE),
    .FILE_ID_BITS (FILE_ID_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .in_valid    (in_bus.valid),
    .in_ready    (in_bus.ready),
    .in_mode     (in_bus.mode),
    .in_desc     (in_bus.descriptor),
    .in_tgt      (in_bus.target_descriptor),
    .in_fid      (in_fid),
    .out_valid   (out_bus.valid),
    .out_ready   (out_bus.ready),
    .out_status  (out_bus.status),
    .out_rd      (out_bus.result_descriptor),
    .out_fid     (out_fid),
    .out_release (out_bus.release_file),
    .alu_op      (alu_op),
    .alu_a       (alu_a),
    .alu_b       (alu_b),
    .alu_res     (alu_res),
    .st_cmd      (st_cmd),
    .slot_addr   (slot_addr),
    .obj_addr    (obj_addr),
    .map_wdata   (map_wdata),
    .file_wdata  (file_wdata),
    .refs_wdata  (refs_wdata),
    .slot_valid  (slot_valid),
    .obj_valid   (obj_valid),
    .map_rdata   (map_rdata),
    .file_rdata  (file_rdata),
    .refs_rdata  (refs_rdata)
  );

endmodule

`default_nettype wire

>>> rtl/rht_alu.sv
// ----------------------------------------------------------------------------
// rht_alu
// Shared 8-bit add/subtract unit: descriptor to slot mapping, slot to
// descriptor numbering and the 8-bit fit check during the free scan.
// ----------------------------------------------------------------------------
`default_nettype none

module rht_alu (
  input  rht_pkg::alu_op_t            op,
  input  logic [rht_pkg::DESC_W-1:0]  a,
  input  logic [rht_pkg::DESC_W-1:0]  b,
  output logic [rht_pkg::DESC_W:0]    res
);
  import rht_pkg::*;

  // res[DESC_W] is carry on add, borrow on subtract
  always_comb begin
    unique case (op)
      ALU_ADD: res = {1'b0, a} + {1'b0, b};
      ALU_SUB: res = {1'b0, a} - {1'b0, b};
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/rht_store.sv
// ----------------------------------------------------------------------------
// rht_store
// Slot and object tables: valid maps in flops, payload in memories with
// registered reads. One address per side each cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rht_store #(
  parameter int TABLE_SIZE   = rht_pkg::DEF_TABLE_SIZE,
  parameter int FILE_ID_BITS = rht_pkg::DEF_FILE_ID_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rht_pkg::store_cmd_t            cmd,
  input  logic [$clog2(TABLE_SIZE)-1:0]  slot_addr,
  input  logic [$clog2(TABLE_SIZE)-1:0]  obj_addr,
  input  logic [$clog2(TABLE_SIZE)-1:0]  map_wdata,
  input  logic [FILE_ID_BITS-1:0]        file_wdata,
  input  logic [rht_pkg::REF_W-1:0]      refs_wdata,
  output logic [TABLE_SIZE-1:0]          slot_valid,
  output logic [TABLE_SIZE-1:0]          obj_valid,
  output logic [$clog2(TABLE_SIZE)-1:0]  map_rdata,
  output logic [FILE_ID_BITS-1:0]        file_rdata,
  output logic [rht_pkg::REF_W-1:0]      refs_rdata
);
  import rht_pkg::*;

  localparam int IW = $clog2(TABLE_SIZE);

  logic [TABLE_SIZE-1:0]   slot_valid_r;
  logic [TABLE_SIZE-1:0]   obj_valid_r;
  logic [IW-1:0]           map_mem [TABLE_SIZE];
  logic [FILE_ID_BITS-1:0] file_mem [TABLE_SIZE];
  logic [REF_W-1:0]        refs_mem [TABLE_SIZE];
  logic [IW-1:0]           map_rd_r;
  logic [FILE_ID_BITS-1:0] file_rd_r;
  logic [REF_W-1:0]        refs_rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      obj_valid_r  <= '0;
    end else begin
      if (cmd.slot_set) begin
        slot_valid_r[slot_addr] <= 1'b1;
      end else if (cmd.slot_clr) begin
        slot_valid_r[slot_addr] <= 1'b0;
      end
      if (cmd.obj_set) begin
        obj_valid_r[obj_addr] <= 1'b1;
      end else if (cmd.obj_clr) begin
        obj_valid_r[obj_addr] <= 1'b0;
      end
    end
  end

  // slot -> object map
  always_ff @(posedge clk) begin
    if (cmd.map_we) begin
      map_mem[slot_addr] <= map_wdata;
    end
    map_rd_r <= map_mem[slot_addr];
  end

  // object file ids
  always_ff @(posedge clk) begin
    if (cmd.file_we) begin
      file_mem[obj_addr] <= file_wdata;
    end
    file_rd_r <= file_mem[obj_addr];
  end

  // object reference counts
  always_ff @(posedge clk) begin
    if (cmd.refs_we) begin
      refs_mem[obj_addr] <= refs_wdata;
    end
    refs_rd_r <= refs_mem[obj_addr];
  end

  assign slot_valid = slot_valid_r;
  assign obj_valid  = obj_valid_r;
  assign map_rdata  = map_rd_r;
  assign file_rdata = file_rd_r;
  assign refs_rdata = refs_rd_r;

endmodule

`default_nettype wire

>>> rtl/rht_ctrl.sv
// ----------------------------------------------------------------------------
// rht_ctrl
// Operation sequencer: decode, table read-modify-write, free-entry scan,
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rht_ctrl #(
  parameter int TABLE_SIZE   = rht_pkg::DEF_TABLE_SIZE,
  parameter int FILE_ID_BITS = rht_pkg::DEF_FILE_ID_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_we,
  input  logic [rht_pkg::DESC_W-1:0]     cfg_data,
  // request
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rht_pkg::MODE_W-1:0]     in_mode,
  input  logic [rht_pkg::DESC_W-1:0]     in_desc,
  input  logic [rht_pkg::DESC_W-1:0]     in_tgt,
  input  logic [FILE_ID_BITS-1:0]        in_fid,
  // result
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rht_pkg::STAT_W-1:0]     out_status,
  output logic [rht_pkg::DESC_W-1:0]     out_rd,
  output logic [FILE_ID_BITS-1:0]        out_fid,
  output logic                           out_release,
  // shared adder
  output rht_pkg::alu_op_t               alu_op,
  output logic [rht_pkg::DESC_W-1:0]     alu_a,
  output logic [rht_pkg::DESC_W-1:0]     alu_b,
  input  logic [rht_pkg::DESC_W:0]       alu_res,
  // tables
  output rht_pkg::store_cmd_t            st_cmd,
  output logic [$clog2(TABLE_SIZE)-1:0]  slot_addr,
  output logic [$clog2(TABLE_SIZE)-1:0]  obj_addr,
  output logic [$clog2(TABLE_SIZE)-1:0]  map_wdata,
  output logic [FILE_ID_BITS-1:0]        file_wdata,
  output logic [rht_pkg::REF_W-1:0]      refs_wdata,
  input  logic [TABLE_SIZE-1:0]          slot_valid,
  input  logic [TABLE_SIZE-1:0]          obj_valid,
  input  logic [$clog2(TABLE_SIZE)-1:0]  map_rdata,
  input  logic [FILE_ID_BITS-1:0]        file_rdata,
  input  logic [rht_pkg::REF_W-1:0]      refs_rdata
);
  import rht_pkg::*;

  localparam int IW = $clog2(TABLE_SIZE);
  localparam logic [IW-1:0]     IDX_LAST = IW'(TABLE_SIZE - 1);
  localparam logic [DESC_W:0]   SIZE_9   = (DESC_W + 1)'(TABLE_SIZE);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC_D,
    S_DEC_T,
    S_SLOT,
    S_OBJ,
    S_TCLOSE,
    S_LINK,
    S_SCAN,
    S_ALLOC,
    S_DONE
  } state_t;

  state_t                  state_r;
  logic [DESC_W-1:0]       base_r;
  logic [MODE_W-1:0]       mode_r;
  logic [DESC_W-1:0]       desc_r;
  logic [DESC_W-1:0]       tgt_r;
  logic [FILE_ID_BITS-1:0] nfid_r;
  logic [IW-1:0]           sd_r;
  logic                    sd_ok_r;
  logic [IW-1:0]           st_r;
  logic                    st_ok_r;
  logic [IW-1:0]           o_r;
  logic [IW-1:0]           ot_r;
  logic [REF_W-1:0]        refs_r;
  logic [IW-1:0]           idx_r;
  logic [IW-1:0]           fo_r;
  logic                    fo_ok_r;
  logic [IW-1:0]           fs_r;
  logic                    fs_ok_r;
  logic [DESC_W-1:0]       fs_desc_r;
  logic [STAT_W-1:0]       sts_r;
  logic [DESC_W-1:0]       rd_r;
  logic [FILE_ID_BITS-1:0] fid_r;
  logic                    rel_r;
  logic                    out_valid_r;
  logic [STAT_W-1:0]       out_status_r;
  logic [DESC_W-1:0]       out_rd_r;
  logic [FILE_ID_BITS-1:0] out_fid_r;
  logic                    out_release_r;

  logic             in_range;
  logic [REF_W-1:0] dec_rd;
  logic             desc_live;
  logic             tgt_live;
  logic             obj_hit;
  logic             slot_hit;
  logic             scan_stop;
  logic             out_load;

  // slot index in range when no borrow and below table size
  assign in_range  = !alu_res[DESC_W] && ({1'b0, alu_res[DESC_W-1:0]} < SIZE_9);
  assign dec_rd    = ref_dec(refs_rdata);
  assign desc_live = sd_ok_r && slot_valid[sd_r] && obj_valid[map_rdata];
  assign tgt_live  = slot_valid[st_r] && obj_valid[map_rdata];

  // free scan: carry out of base + idx means no 8-bit descriptor
  assign obj_hit   = (mode_r == MODE_OPEN) && !fo_ok_r && !obj_valid[idx_r];
  assign slot_hit  = !fs_ok_r && !slot_valid[idx_r] && !alu_res[DESC_W];
  assign scan_stop = (idx_r == IDX_LAST) ||
                     ((fs_ok_r || slot_hit) &&
                      ((mode_r != MODE_OPEN) || fo_ok_r || obj_hit));

  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign in_ready  = (state_r == S_IDLE);

  always_comb begin
    st_cmd     = '0;
    slot_addr  = sd_r;
    obj_addr   = o_r;
    map_wdata  = o_r;
    file_wdata = nfid_r;
    refs_wdata = ref_inc(refs_r);
    alu_op     = ALU_SUB;
    alu_a      = desc_r;
    alu_b      = base_r;
    unique case (state_r)
      S_DEC_T: begin
        alu_a = tgt_r;
      end
      S_SLOT: begin
        slot_addr = st_r;
        obj_addr  = map_rdata;
      end
      S_OBJ: begin
        if (mode_r == MODE_DUP2) begin
          obj_addr = map_rdata;
        end else if (mode_r == MODE_CLOSE) begin
          st_cmd.refs_we  = 1'b1;
          st_cmd.slot_clr = 1'b1;
          st_cmd.obj_clr  = (dec_rd == REF_ZERO);
          refs_wdata      = dec_rd;
        end
      end
      S_TCLOSE: begin
        obj_addr       = ot_r;
        st_cmd.refs_we = 1'b1;
        st_cmd.obj_clr = (dec_rd == REF_ZERO);
        refs_wdata     = dec_rd;
      end
      S_LINK: begin
        slot_addr       = st_r;
        st_cmd.slot_set = 1'b1;
        st_cmd.map_we   = 1'b1;
        st_cmd.refs_we  = 1'b1;
      end
      S_SCAN: begin
        alu_op = ALU_ADD;
        alu_a  = base_r;
        alu_b  = DESC_W'(idx_r);
      end
      S_ALLOC: begin
        slot_addr = fs_r;
        if (mode_r == MODE_OPEN) begin
          if (fo_ok_r && fs_ok_r) begin
            obj_addr        = fo_r;
            map_wdata       = fo_r;
            refs_wdata      = REF_ONE;
            st_cmd.obj_set  = 1'b1;
            st_cmd.file_we  = 1'b1;
            st_cmd.refs_we  = 1'b1;
            st_cmd.slot_set = 1'b1;
            st_cmd.map_we   = 1'b1;
          end
        end else if (fs_ok_r) begin
          st_cmd.slot_set = 1'b1;
          st_cmd.map_we   = 1'b1;
          st_cmd.refs_we  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= BASE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        base_r <= cfg_data;
      end

      if (out_load) begin
        out_valid_r   <= 1'b1;
        out_status_r  <= sts_r;
        out_rd_r      <= rd_r;
        out_fid_r     <= fid_r;
        out_release_r <= rel_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mode_r  <= in_mode;
            desc_r  <= in_desc;
            tgt_r   <= in_tgt;
            nfid_r  <= in_fid;
            state_r <= S_DEC_D;
          end
        end
        S_DEC_D: begin
          sd_r    <= alu_res[IW-1:0];
          sd_ok_r <= in_range;
          sts_r   <= STS_OK;
          rd_r    <= '0;
          fid_r   <= '0;
          rel_r   <= 1'b0;
          idx_r   <= '0;
          fo_ok_r <= 1'b0;
          fs_ok_r <= 1'b0;
          unique case (mode_r)
            MODE_OPEN: state_r <= S_SCAN;
            MODE_CLOSE, MODE_DUP, MODE_DUP2, MODE_LOOKUP: state_r <= S_DEC_T;
            default: begin
              sts_r   <= STS_UNSUPPORTED;
              state_r <= S_DONE;
            end
          endcase
        end
        S_DEC_T: begin
          st_r    <= alu_res[IW-1:0];
          st_ok_r <= in_range;
          state_r <= S_SLOT;
        end
        S_SLOT: begin
          if (desc_live) begin
            o_r     <= map_rdata;
            state_r <= S_OBJ;
          end else begin
            sts_r   <= STS_INVALID;
            state_r <= S_DONE;
          end
        end
        S_OBJ: begin
          refs_r <= refs_rdata;
          unique case (mode_r)
            MODE_CLOSE: begin
              if (dec_rd == REF_ZERO) begin
                rel_r <= 1'b1;
                fid_r <= file_rdata;
              end
              state_r <= S_DONE;
            end
            MODE_LOOKUP: begin
              rd_r    <= desc_r;
              fid_r   <= file_rdata;
              state_r <= S_DONE;
            end
            MODE_DUP: state_r <= S_SCAN;
            default: begin
              // dup2: target checked only once the source is known good
              if (!st_ok_r) begin
                sts_r   <= STS_UNSUPPORTED;
                state_r <= S_DONE;
              end else begin
                rd_r <= tgt_r;
                if (tgt_r == desc_r) begin
                  state_r <= S_DONE;
                end else if (tgt_live) begin
                  ot_r    <= map_rdata;
                  state_r <= S_TCLOSE;
                end else begin
                  state_r <= S_LINK;
                end
              end
            end
          endcase
        end
        S_TCLOSE: begin
          if (dec_rd == REF_ZERO) begin
            rel_r <= 1'b1;
            fid_r <= file_rdata;
          end
          // target shared the source object: keep the held count current
          if (ot_r == o_r) begin
            refs_r <= dec_rd;
          end
          state_r <= S_LINK;
        end
        S_LINK: begin
          state_r <= S_DONE;
        end
        S_SCAN: begin
          if (obj_hit) begin
            fo_r    <= idx_r;
            fo_ok_r <= 1'b1;
          end
          if (slot_hit) begin
            fs_r      <= idx_r;
            fs_ok_r   <= 1'b1;
            fs_desc_r <= alu_res[DESC_W-1:0];
          end
          idx_r <= idx_r + 1'b1;
          if (scan_stop) begin
            state_r <= S_ALLOC;
          end
        end
        S_ALLOC: begin
          if (mode_r == MODE_OPEN) begin
            if (fo_ok_r && fs_ok_r) begin
              rd_r <= fs_desc_r;
            end else begin
              sts_r <= STS_FULL;
              fid_r <= nfid_r;
              rel_r <= 1'b1;
            end
          end else if (fs_ok_r) begin
            rd_r <= fs_desc_r;
          end else begin
            sts_r <= STS_FULL;
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_rd      = out_rd_r;
  assign out_fid     = out_fid_r;
  assign out_release = out_release_r;

`ifndef NO_ASSERTIONS
  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside done state");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while busy");

  a_no_set_clr: assert property (@(posedge clk) disable iff (!rst_n)
    !(st_cmd.slot_set && st_cmd.slot_clr) && !(st_cmd.obj_set && st_cmd.obj_clr))
    else $error("valid bit set and cleared together");

  a_open_free_obj: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ALLOC && mode_r == MODE_OPEN && fo_ok_r) |-> !obj_valid[fo_r])
    else $error("open allocating a live object");

  a_release_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_release_r) |-> (out_status_r == STS_OK || out_status_r == STS_FULL))
    else $error("release with error status");
`endif

endmodule

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the refcounted handle table. A mirror of the
// descriptor table predicts every result beat from the accepted requests;
// results are compared field by field in order. Runs a directed opening,
// then random phases across several descriptor bases and handshake regimes.
// ----------------------------------------------------------------------------

import rht_pkg::*;

typedef struct packed {
  logic [MODE_W-1:0]     mode;
  logic [DESC_W-1:0]     desc;
  logic [DESC_W-1:0]     tgt;
  logic [FID_PORT_W-1:0] fid;
} fd_request_t;

typedef struct packed {
  logic [STAT_W-1:0]     status;
  logic [DESC_W-1:0]     rdesc;
  logic [FID_PORT_W-1:0] fid;
  logic                  drop_fid;
} fd_result_t;

// Mirror of the descriptor table plus the queue of results still owed.
class handle_table_mirror;
  logic [DESC_W-1:0]     base;
  bit                    slot_used [DEF_TABLE_SIZE];
  int                    slot_obj  [DEF_TABLE_SIZE];
  bit                    obj_used  [DEF_TABLE_SIZE];
  logic [FID_PORT_W-1:0] obj_fid   [DEF_TABLE_SIZE];
  logic [REF_W-1:0]      obj_refs  [DEF_TABLE_SIZE];
  fd_result_t            owed [$];
  int                    errors;

  function new();
    base   = BASE_RESET;
    errors = 0;
  endfunction

  function int slot_at(logic [DESC_W-1:0] d);
    int off;
    off = int'(d) - int'(base);
    if (off < 0 || off >= DEF_TABLE_SIZE) return -1;
    return off;
  endfunction

  function int object_at(logic [DESC_W-1:0] d);
    int s;
    s = slot_at(d);
    if (s < 0 || !slot_used[s]) return -1;
    if (!obj_used[slot_obj[s]]) return -1;
    return slot_obj[s];
  endfunction

  // Only slots whose descriptor number fits in 8 bits can be handed out.
  function int first_free_slot();
    int i;
    for (i = 0; i < DEF_TABLE_SIZE; i++)
      if (!slot_used[i] && int'(base) + i <= 255) return i;
    return -1;
  endfunction

  // Caller has already checked that d is open.
  function void drop_slot(logic [DESC_W-1:0] d, inout fd_result_t r);
    int s;
    int o;
    s = slot_at(d);
    o = object_at(d);
    slot_used[s] = 1'b0;
    if (obj_refs[o] != REF_ZERO) obj_refs[o] = obj_refs[o] - REF_ONE;
    if (obj_refs[o] == REF_ZERO) begin
      r.fid      = obj_fid[o];
      r.drop_fid = 1'b1;
      obj_used[o] = 1'b0;
    end
  endfunction

  function void bump_refs(int o);
    if (obj_refs[o] != REF_MAX) obj_refs[o] = obj_refs[o] + REF_ONE;
  endfunction

  function void note_request(fd_request_t q);
    fd_result_t r;
    int o;
    int s;
    int i;
    r = '0;
    case (q.mode)
      MODE_OPEN: begin
        o = -1;
        for (i = 0; i < DEF_TABLE_SIZE; i++)
          if (o < 0 && !obj_used[i]) o = i;
        s = first_free_slot();
        if (o < 0 || s < 0) begin
          r.status   = STS_FULL;
          r.fid      = q.fid;
          r.drop_fid = 1'b1;
        end else begin
          obj_used[o]  = 1'b1;
          obj_fid[o]   = q.fid;
          obj_refs[o]  = REF_ONE;
          slot_used[s] = 1'b1;
          slot_obj[s]  = o;
          r.rdesc      = base + DESC_W'(s);
        end
      end
      MODE_CLOSE: begin
        if (object_at(q.desc) < 0) r.status = STS_INVALID;
        else drop_slot(q.desc, r);
      end
      MODE_DUP: begin
        o = object_at(q.desc);
        s = first_free_slot();
        if (o < 0) begin
          r.status = STS_INVALID;
        end else if (s < 0) begin
          r.status = STS_FULL;
        end else begin
          slot_used[s] = 1'b1;
          slot_obj[s]  = o;
          bump_refs(o);
          r.rdesc = base + DESC_W'(s);
        end
      end
      MODE_DUP2: begin
        o = object_at(q.desc);
        s = slot_at(q.tgt);
        if (o < 0) begin
          r.status = STS_INVALID;
        end else if (s < 0) begin
          r.status = STS_UNSUPPORTED;
        end else begin
          r.rdesc = q.tgt;
          if (q.tgt != q.desc) begin
            if (object_at(q.tgt) >= 0) drop_slot(q.tgt, r);
            slot_used[s] = 1'b1;
            slot_obj[s]  = o;
            bump_refs(o);
          end
        end
      end
      MODE_LOOKUP: begin
        o = object_at(q.desc);
        if (o < 0) begin
          r.status = STS_INVALID;
        end else begin
          r.rdesc = q.desc;
          r.fid   = obj_fid[o];
        end
      end
      default: r.status = STS_UNSUPPORTED;
    endcase
    owed.push_back(r);
  endfunction

  function void check_result(fd_result_t got);
    fd_result_t want;
    if (owed.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("ERROR: result beat with nothing owed: sts=%0d desc=%0d fid=%h rel=%b",
                 got.status, got.rdesc, got.fid, got.drop_fid);
      return;
    end
    want = owed.pop_front();
    if (got.status !== want.status || got.rdesc !== want.rdesc ||
        got.fid !== want.fid || got.drop_fid !== want.drop_fid) begin
      errors++;
      if (errors <= 10)
        $display("ERROR: result mismatch: exp sts=%0d desc=%0d fid=%h rel=%b,",
                 want.status, want.rdesc, want.fid, want.drop_fid,
                 " got sts=%0d desc=%0d fid=%h rel=%b",
                 got.status, got.rdesc, got.fid, got.drop_fid);
    end
  endfunction
endclass

module tb;
  import rht_pkg::*;

  localparam int RANDOM_PER_PHASE = 285;
  localparam int PHASES           = 7;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [DESC_W-1:0] cfg_data;

  rht_in_if  in_bus ();
  rht_out_if out_bus ();

  refcounted_handle_table_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_bus   (in_bus),
    .out_bus  (out_bus)
  );

  handle_table_mirror tbl = new();

  // percent of cycles the sender holds off / the receiver holds ready low
  int send_gap_pct;
  int ready_stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop. Worst case is roughly 2k beats.
  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Result side backpressure, re-rolled every cycle.
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_bus.ready <= ($urandom_range(99) >= ready_stall_pct);
    end
  end

  // Observe both channels at the edge; predict on request beats, check on
  // result beats.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready)
        tbl.note_request('{mode: in_bus.mode, desc: in_bus.descriptor,
                           tgt: in_bus.target_descriptor, fid: in_bus.new_file_id});
      if (out_bus.valid && out_bus.ready)
        tbl.check_result('{status: out_bus.status, rdesc: out_bus.result_descriptor,
                           fid: out_bus.file_id_out, drop_fid: out_bus.release_file});
    end
  end

  function automatic fd_request_t mk(logic [MODE_W-1:0] m, logic [DESC_W-1:0] d,
                                     logic [DESC_W-1:0] t, logic [FID_PORT_W-1:0] f);
    fd_request_t q;
    q.mode = m;
    q.desc = d;
    q.tgt  = t;
    q.fid  = f;
    return q;
  endfunction

  // Mostly open descriptors so requests get past the validity checks; the
  // rest sit just off the table edges, inside it, or anywhere in the byte.
  function automatic logic [DESC_W-1:0] pick_desc();
    int live [$];
    int k;
    for (k = 0; k < DEF_TABLE_SIZE; k++)
      if (tbl.slot_used[k]) live.push_back(k);
    if (live.size() != 0 && $urandom_range(9) < 7)
      return tbl.base + DESC_W'(live[$urandom_range(live.size() - 1)]);
    case ($urandom_range(3))
      0:       return tbl.base - 8'd1;
      1:       return tbl.base + 8'd64;
      2:       return tbl.base + DESC_W'($urandom_range(63));
      default: return DESC_W'($urandom_range(255));
    endcase
  endfunction

  function automatic fd_request_t random_request(int open_pct);
    fd_request_t q;
    int r;
    q.desc = pick_desc();
    q.tgt  = pick_desc();
    q.fid  = $urandom();
    r = $urandom_range(99);
    if (r < 4) begin
      // undefined opcodes above lookup
      q.mode = MODE_LOOKUP + MODE_W'($urandom_range(3, 1));
    end else if (r < 4 + open_pct) begin
      q.mode = MODE_OPEN;
    end else begin
      case ($urandom_range(3))
        0:       q.mode = MODE_CLOSE;
        1:       q.mode = MODE_DUP;
        2:       q.mode = MODE_DUP2;
        default: q.mode = MODE_LOOKUP;
      endcase
    end
    if (q.mode == MODE_DUP2 && $urandom_range(9) == 0) q.tgt = q.desc;
    return q;
  endfunction

  // Starts at a clock edge, returns at the edge where the beat was taken.
  // valid is left high so back-to-back beats need no second assignment.
  task automatic send(input fd_request_t q);
    while ($urandom_range(99) < send_gap_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid             <= 1'b1;
    in_bus.mode              <= q.mode;
    in_bus.descriptor        <= q.desc;
    in_bus.target_descriptor <= q.tgt;
    in_bus.new_file_id       <= q.fid;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // Hold off the sender until every owed result is back, plus some slack.
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (tbl.owed.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_base(input logic [DESC_W-1:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    tbl.base = v;
  endtask

  initial begin
    int p;
    int n;
    logic [DESC_W-1:0] nb;

    rst_n                    <= 1'b0;
    cfg_we                   <= 1'b0;
    cfg_data                 <= '0;
    in_bus.valid             <= 1'b0;
    in_bus.mode              <= MODE_OPEN;
    in_bus.descriptor        <= '0;
    in_bus.target_descriptor <= '0;
    in_bus.new_file_id       <= '0;
    send_gap_pct    = 25;
    ready_stall_pct = 84;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening at the reset base of 64: empty table, file id
    // extremes, dup and dup2 paths, dup2 onto itself, dup2 onto an open
    // slot, targets outside the table, releases on close, bad opcodes.
    send(mk(MODE_LOOKUP, 8'd64, 8'd0,  32'h0));
    send(mk(MODE_CLOSE,  8'd64, 8'd0,  32'h0));
    send(mk(MODE_DUP,    8'd64, 8'd0,  32'h0));
    send(mk(MODE_DUP2,   8'd64, 8'd65, 32'h0));
    send(mk(MODE_OPEN,   8'd0,  8'd0,  32'h0000_0000));
    send(mk(MODE_OPEN,   8'd0,  8'd0,  32'hFFFF_FFFF));
    send(mk(MODE_OPEN,   8'd0,  8'd0,  32'hA5A5_5A5A));
    send(mk(MODE_LOOKUP, 8'd64, 8'd0,  32'h0));
    send(mk(MODE_LOOKUP, 8'd65, 8'd0,  32'h0));
    send(mk(MODE_DUP,    8'd65, 8'd0,  32'h0));
    send(mk(MODE_DUP2,   8'd65, 8'd65, 32'h0));
    send(mk(MODE_DUP2,   8'd65, 8'd66, 32'h0));
    send(mk(MODE_DUP2,   8'd64, 8'd200, 32'h0));
    send(mk(MODE_DUP2,   8'd64, 8'd63, 32'h0));
    send(mk(MODE_DUP2,   8'd64, 8'd67, 32'h0));
    send(mk(MODE_LOOKUP, 8'd63, 8'd0,  32'h0));
    send(mk(MODE_LOOKUP, 8'd128, 8'd0, 32'h0));
    send(mk(MODE_LOOKUP, 8'd127, 8'd0, 32'h0));
    send(mk(MODE_CLOSE,  8'd65, 8'd0,  32'h0));
    send(mk(MODE_CLOSE,  8'd66, 8'd0,  32'h0));
    send(mk(MODE_CLOSE,  8'd67, 8'd0,  32'h0));
    send(mk(MODE_LOOKUP + 3'd1, 8'd0,   8'd0,   32'h0));
    send(mk(MODE_LOOKUP + 3'd2, 8'd64,  8'd64,  32'h1234_5678));
    send(mk(MODE_LOOKUP + 3'd3, 8'd255, 8'd255, 32'hFFFF_FFFF));
    send(mk(MODE_OPEN,   8'd255, 8'd255, 32'h8000_0001));

    // Random phases. Each new base is written with the table idle; open
    // descriptors keep their slots and are simply renumbered. Bases above
    // 192 leave the top slots unreachable, so the table fills early.
    for (p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        drain_results();
        case (p)
          1:       nb = 8'd0;
          2:       nb = 8'd192;
          3:       nb = 8'd250;
          4:       nb = 8'd255;
          5:       nb = DESC_W'($urandom_range(255));
          default: nb = BASE_RESET;
        endcase
        write_base(nb);
      end
      // handshake regime: slow receiver, then slow sender, then full rate
      if (p < 2) begin
        send_gap_pct    = 25;
        ready_stall_pct = 84;
      end else if (p < 4) begin
        send_gap_pct    = 84;
        ready_stall_pct = 25;
      end else begin
        send_gap_pct    = 0;
        ready_stall_pct = 0;
      end
      // alternate open-heavy phases (table fills) with close-heavy ones
      for (n = 0; n < RANDOM_PER_PHASE; n++)
        send(random_request((p % 2 == 0) ? 45 : 15));
    end

    drain_results();
    if (tbl.errors == 0 && tbl.owed.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/rht_pkg.sv
rtl/rht_if.sv
rtl/rht_alu.sv
rtl/rht_store.sv
rtl/rht_ctrl.sv
rtl/refcounted_handle_table_top.sv
dv/tb.sv
